>>> rtl/core/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam int CMD_W  = 3;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;
    localparam int POS_W  = 3;
    localparam int SIZE_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_TOP = 3'd0,
        CMD_POP_TOP  = 3'd1,
        CMD_PUSH_BOT = 3'd2,
        CMD_POP_BOT  = 3'd3,
        CMD_LIST     = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_HEADER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value_res;
        logic [SIZE_W-1:0]  size;
        logic               last;
    } res_t;

endpackage

>>> rtl/core/deq_req_if.sv
interface deq_req_if import deq_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);

endinterface

>>> rtl/core/deq_rsp_if.sv
interface deq_rsp_if import deq_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value_res;
    logic [SIZE_W-1:0]  size;
    logic               last;

    modport source (output valid, output status, output position, output value_res,
                    output size, output last, input ready);
    modport sink   (input valid, input status, input position, input value_res,
                    input size, input last, output ready);

endinterface

>>> rtl/core/deq_mem.sv
module deq_mem import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [VAL_W-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [VAL_W-1:0]          rdata
);

    logic [VAL_W-1:0] store_reg [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic [CMD_W-1:0]          req_cmd,
    input  logic [VAL_W-1:0]          req_value,
    output logic                      req_ready,
    input  logic                      out_free,
    output logic                      res_load,
    output res_t                      res_data,
    output logic                      mem_we,
    output logic [$clog2(DEPTH)-1:0]  mem_waddr,
    output logic [VAL_W-1:0]          mem_wdata,
    output logic                      mem_re,
    output logic [$clog2(DEPTH)-1:0]  mem_raddr,
    input  logic [VAL_W-1:0]          mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
    localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    res_t            pend_reg, pend_next;

    logic            accept;
    logic            is_full;
    logic            is_empty;
    logic [FW-1:0]   fill_inc;
    logic [FW-1:0]   fill_dec;
    logic [AW-1:0]   base_inc;
    logic [AW-1:0]   base_dec;

    // logical index to physical address, circular from base
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_A)
        begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign is_full  = (fill_reg == DEPTH_F);
    assign is_empty = (fill_reg == '0);
    assign fill_inc = fill_reg + 1'b1;
    assign fill_dec = fill_reg - 1'b1;
    assign base_inc = (base_reg == TOP_IDX) ? '0 : base_reg + 1'b1;
    assign base_dec = (base_reg == '0) ? TOP_IDX : base_reg - 1'b1;

    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            base_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        res_load   = 1'b0;
        res_data   = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = req_value;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_cmd)
                        CMD_PUSH_TOP:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res_data = '{ST_FULL, '0, '0, SIZE_W'(fill_reg), 1'b1};
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wrap_add(base_reg, AW'(fill_reg));
                                fill_next = fill_inc;
                                res_data  = '{ST_DONE, POS_W'(fill_reg), req_value,
                                              SIZE_W'(fill_inc), 1'b1};
                            end
                        end
                        CMD_POP_TOP:
                        begin
                            if (is_empty)
                            begin
                                res_load = 1'b1;
                                res_data = '{ST_EMPTY, '0, '0, '0, 1'b1};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = wrap_add(base_reg, AW'(fill_dec));
                                fill_next  = fill_dec;
                                pend_next  = '{ST_DONE, POS_W'(fill_dec), '0,
                                               SIZE_W'(fill_dec), 1'b1};
                                state_next = S_POP;
                            end
                        end
                        CMD_PUSH_BOT:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res_data = '{ST_FULL, '0, '0, SIZE_W'(fill_reg), 1'b1};
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = base_dec;
                                base_next = base_dec;
                                fill_next = fill_inc;
                                res_data  = '{ST_DONE, '0, req_value,
                                              SIZE_W'(fill_inc), 1'b1};
                            end
                        end
                        CMD_POP_BOT:
                        begin
                            if (is_empty)
                            begin
                                res_load = 1'b1;
                                res_data = '{ST_EMPTY, '0, '0, '0, 1'b1};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = base_reg;
                                base_next  = base_inc;
                                fill_next  = fill_dec;
                                pend_next  = '{ST_DONE, '0, '0, SIZE_W'(fill_dec), 1'b1};
                                state_next = S_POP;
                            end
                        end
                        CMD_LIST:
                        begin
                            res_load = 1'b1;
                            res_data = '{ST_HEADER, '0, '0, SIZE_W'(fill_reg), is_empty};
                            if (!is_empty)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = wrap_add(base_reg, AW'(fill_dec));
                                cnt_next   = AW'(fill_dec);
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // unused codes: no result
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    res_load           = 1'b1;
                    res_data           = pend_reg;
                    res_data.value_res = mem_rdata;
                    state_next         = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_data = '{ST_DONE, POS_W'(cnt_reg), mem_rdata,
                                 SIZE_W'(fill_reg), (cnt_reg == '0)};
                    if (cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg - 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = wrap_add(base_reg, cnt_reg - 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_F)
        else $error("fill beyond depth");

    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= TOP_IDX)
        else $error("base pointer out of range");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("read and write in one cycle");

    a_list_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) && $past(state_reg == S_LIST)
        |-> $stable(base_reg) && $stable(fill_reg))
        else $error("store changed during listing");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded into a busy output stage");
`endif

endmodule

>>> rtl/core/double_ended_char_stack.sv
// double-ended byte stack of DEPTH entries
// channels: req carries one command (cmd, value) per transfer; rsp carries
// result items (status, position, value_res, size, last), last marking the
// final result of a command
// push top, push bottom and rejected commands: one result, in the output
// register on the cycle after the transfer; no busy state follows
// pops: the entry is read into the store's read register, and the result goes
// to the output register from state S_POP; no command is taken in S_POP
// list: header in the output register on the cycle after the transfer, then one
// entry per cycle from the top down while the output register is free, fill + 1
// results in all; the store's single registered read port sets this pace
// bottom pushes and pops move a base pointer round the circular store, so no
// entry is ever shifted
// reset: store empty, base at zero; store contents are not cleared
// a stalled receiver holds the output register; no new command is taken and
// listing pauses until the result is taken
module double_ended_char_stack import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       req,
    deq_rsp_if.source     rsp
);

    localparam int AW = $clog2(DEPTH);

    // output register
    logic             out_valid_reg;
    res_t             out_data_reg;
    logic             out_free;

    // controller to output register and store
    logic             res_load;
    res_t             res_data;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    // free now, or emptied by the transfer at this edge
    assign out_free = !out_valid_reg || rsp.ready;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_value (req.value),
        .req_ready (req.ready),
        .out_free  (out_free),
        .res_load  (res_load),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    deq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res_data;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_data_reg.status;
    assign rsp.position  = out_data_reg.position;
    assign rsp.value_res = out_data_reg.value_res;
    assign rsp.size      = out_data_reg.size;
    assign rsp.last      = out_data_reg.last;

endmodule

>>> verif/double_ended_char_stack_test.sv
module double_ended_char_stack_test;
    import deq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    // cycles with no transfer on either channel before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // longest run of results one command can cause, with margin for the pop latency
    localparam int SETTLE_CYCLES = 2 * DEPTH + 6;
    // receiver hold-off used to back the block up
    localparam int LONG_HOLD = 90;

    logic clk;
    logic rst_n;

    deq_req_if req ();
    deq_rsp_if rsp ();

    double_ended_char_stack #(.DEPTH(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the stack: index 0 is the bottom, held_count entries valid
    logic [VAL_W-1:0] held_bytes [DEPTH];
    int unsigned      held_count = 0;

    // results still owed by the block, oldest first
    res_t results_due [$];

    int error_count   = 0;
    int rx_hold_left  = 0;   // cycles the receiver still has to hold off
    bit steady_tail   = 1'b0; // no idling on either side once set
    bit fill_bias     = 1'b1; // random traffic leans towards pushes when set

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one line per mismatch, and a count for the final verdict
    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h (%0d still due)",
                                      name, got, want, results_due.size()));
    endtask

    // work out the results of one accepted command and update the shadow stack
    function automatic void predict_stack_results(input logic [CMD_W-1:0] c,
                                                  input logic [VAL_W-1:0] v);
        res_t r;
        int   i;
        r      = '0;
        r.last = 1'b1;
        case (c)
            CMD_PUSH_TOP, CMD_PUSH_BOT:
            begin
                if (held_count >= DEPTH)
                begin
                    // full store: rejected, nothing changes
                    r.status = ST_FULL;
                    r.size   = SIZE_W'(held_count);
                end
                else
                begin
                    if (c == CMD_PUSH_TOP)
                    begin
                        held_bytes[held_count] = v;
                        r.position = POS_W'(held_count);
                    end
                    else
                    begin
                        // every held entry moves up one place
                        for (i = held_count; i > 0; i--)
                            held_bytes[i] = held_bytes[i - 1];
                        held_bytes[0] = v;
                        r.position = '0;
                    end
                    held_count++;
                    r.status    = ST_DONE;
                    r.value_res = v;
                    r.size      = SIZE_W'(held_count);
                end
                results_due.push_back(r);
            end
            CMD_POP_TOP, CMD_POP_BOT:
            begin
                if (held_count == 0)
                begin
                    // empty store: rejected, size reads zero
                    r.status = ST_EMPTY;
                end
                else if (c == CMD_POP_TOP)
                begin
                    held_count--;
                    r.status    = ST_DONE;
                    r.position  = POS_W'(held_count);
                    r.value_res = held_bytes[held_count];
                    r.size      = SIZE_W'(held_count);
                end
                else
                begin
                    // remaining entries move down one place
                    r.status    = ST_DONE;
                    r.position  = '0;
                    r.value_res = held_bytes[0];
                    for (i = 0; i + 1 < held_count; i++)
                        held_bytes[i] = held_bytes[i + 1];
                    held_count--;
                    r.size = SIZE_W'(held_count);
                end
                results_due.push_back(r);
            end
            CMD_LIST:
            begin
                // header first, marked last only when there is nothing to list
                r.status = ST_HEADER;
                r.size   = SIZE_W'(held_count);
                r.last   = (held_count == 0);
                results_due.push_back(r);
                for (i = held_count; i > 0; i--)
                begin
                    r.status    = ST_DONE;
                    r.position  = POS_W'(i - 1);
                    r.value_res = held_bytes[i - 1];
                    r.size      = SIZE_W'(held_count);
                    r.last      = (i == 1);
                    results_due.push_back(r);
                end
            end
            default:
            begin
                // unused codes are swallowed without a result
            end
        endcase
    endfunction

    // offer one command from the next falling edge and hold it until the transfer;
    // valid is left high so back-to-back commands follow without a gap
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v);
        @(negedge clk);
        req.valid <= 1'b1;
        req.cmd   <= c;
        req.value <= v;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        predict_stack_results(c, v);
    endtask

    // sender gap: valid low, payload scrambled so the block has to ignore it
    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            req.cmd   <= CMD_W'($urandom);
            req.value <= VAL_W'($urandom);
        end
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic wait_for_drain();
        pause_sender(1);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // mostly pushes and pops, some listings, a few unused codes
    task automatic send_random_command();
        logic [CMD_W-1:0] c;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            c = CMD_W'($urandom_range(5, 7));
        else if (pick < 14)
            c = CMD_LIST;
        else if ($urandom_range(0, 99) < (fill_bias ? 70 : 30))
            c = $urandom_range(0, 1) ? CMD_PUSH_TOP : CMD_PUSH_BOT;
        else
            c = $urandom_range(0, 1) ? CMD_POP_TOP : CMD_POP_BOT;
        send_command(c, VAL_W'($urandom));
    endtask

    // empty store straight after reset: listing and both pops
    task automatic test_empty_store();
        send_command(CMD_LIST, 8'h00);
        send_command(CMD_POP_TOP, 8'hFF);
        send_command(CMD_POP_BOT, 8'h00);
        wait_for_drain();
    endtask

    // fill from both ends, reject when full, list a full store, unused codes,
    // then take from both ends and list again
    task automatic test_fill_and_reject();
        send_command(CMD_PUSH_TOP, 8'h00);
        send_command(CMD_PUSH_TOP, 8'hFF);
        send_command(CMD_PUSH_BOT, 8'hAA);
        send_command(CMD_PUSH_BOT, 8'h55);
        send_command(CMD_PUSH_TOP, 8'h0F);
        send_command(CMD_PUSH_BOT, 8'hF0);
        send_command(CMD_PUSH_TOP, 8'h80);
        send_command(CMD_PUSH_BOT, 8'h01);
        send_command(CMD_PUSH_TOP, 8'h7E);
        send_command(CMD_PUSH_BOT, 8'h81);
        send_command(CMD_LIST, 8'h00);
        send_command(CMD_W'(5), 8'hFF);
        send_command(CMD_W'(6), 8'h00);
        send_command(CMD_W'(7), 8'hFF);
        send_command(CMD_POP_TOP, 8'h00);
        send_command(CMD_POP_BOT, 8'h00);
        send_command(CMD_LIST, 8'hFF);
        wait_for_drain();
    endtask

    // receiver holds off for a long stretch while commands keep coming, so the
    // output register fills and the block stops taking transfers
    task automatic test_backpressure();
        rx_hold_left = LONG_HOLD;
        send_command(CMD_LIST, 8'h00);
        repeat (12)
            send_random_command();
        wait_for_drain();
    endtask

    // random traffic with idling on both sides; the bias flips now and then so
    // the store swings between empty and full
    task automatic test_random_traffic();
        int n;
        for (n = 0; n < 60; n++)
        begin
            if (n % 20 == 19)
                fill_bias = ~fill_bias;
            if ($urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 17));
            if ($urandom_range(0, 39) == 0)
                wait_for_drain();
            send_random_command();
        end
        wait_for_drain();
    endtask

    // back-to-back transfers with the receiver always ready
    task automatic test_steady_tail();
        steady_tail = 1'b1;
        repeat (30)
            send_random_command();
        wait_for_drain();
    endtask

    // stimulus and final verdict
    initial
    begin : stimulus
        req.valid = 1'b0;
        req.cmd   = '0;
        req.value = '0;
        rst_n     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_fill_and_reject();
        test_backpressure();
        test_random_traffic();
        test_steady_tail();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver: long hold-off on request, otherwise random bursts of ready and
    // not ready, always ready in the steady tail
    initial
    begin : receiver
        int burst_left;
        bit burst_ready;
        burst_left  = 0;
        burst_ready = 1'b0;
        rsp.ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (steady_tail)
                rsp.ready <= 1'b1;
            else
            begin
                if (burst_left == 0)
                begin
                    burst_ready = ($urandom_range(0, 2) != 0);
                    burst_left  = burst_ready ? $urandom_range(1, 24) : $urandom_range(1, 17);
                end
                burst_left--;
                rsp.ready <= burst_ready;
            end
        end
    end

    // every result transfer is matched against the oldest owed result
    initial
    begin : result_checker
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (results_due.size() == 0)
                    report_mismatch($sformatf("result transfer with nothing owed, status %0d",
                                              rsp.status));
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", 8'(rsp.status), 8'(want.status));
                    check_field("position", 8'(rsp.position), 8'(want.position));
                    check_field("value_res", rsp.value_res, want.value_res);
                    check_field("size", 8'(rsp.size), 8'(want.size));
                    check_field("last", 8'(rsp.last), 8'(want.last));
                end
            end
        end
    end

    // hang detection: too long without a transfer on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/deq_pkg.sv
rtl/core/deq_req_if.sv
rtl/core/deq_rsp_if.sv
rtl/core/deq_mem.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_char_stack.sv
verif/double_ended_char_stack_test.sv
